// ===== rtl/core/keyed_variable_table_assert.svh =====
// ----------------------------------------------------------------------------
// Keyed variable table assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYED_VARIABLE_TABLE_ASSERT_SVH
`define KEYED_VARIABLE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define KVT_ASSERT(name, clock, resetn, prop, msg) \
	name: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
`define KVT_NEVER(name, clock, resetn, expr, msg) \
	name: assert property (@(posedge clock) disable iff (!resetn) !(expr)) else $error(msg);
`else
`define KVT_ASSERT(name, clock, resetn, prop, msg)
`define KVT_NEVER(name, clock, resetn, expr, msg)
`endif
`endif

// ===== rtl/core/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed variable table package
// Field widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int KEY_W      = 8;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 21;
	localparam int SLOT_W     = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_FLASH_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE  = 1'b1;

	localparam logic [SLOT_W-1:0] SLOT_SIZE_RESET = 13'd256;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_SELECT = 1'b1;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} kvt_cmd_t;

	typedef struct packed {
		logic scan_last;
	} kvt_sts_t;

endpackage

// ===== rtl/core/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Keyed variable table controller
// Sequences one transaction: load, row scan, pipeline drain and commit.
// ----------------------------------------------------------------------------
`include "keyed_variable_table_assert.svh"

module kvt_ctrl import kvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  kvt_sts_t sts,
	output kvt_cmd_t cmd,
	output logic     busy
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			// The compare of the last row read happens in this cycle.
			ST_DRAIN: begin
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

	`KVT_NEVER(a_cmd_onehot, clk, arst_n, !$onehot0({cmd.load, cmd.scan, cmd.commit}), "more than one command at once")
	`KVT_ASSERT(a_load_then_scan, clk, arst_n, cmd.load |=> cmd.scan, "load not followed by scan")
	`KVT_ASSERT(a_commit_then_idle, clk, arst_n, cmd.commit |=> !busy, "busy after commit")

endmodule

// ===== rtl/core/kvt_dpath.sv =====
// ----------------------------------------------------------------------------
// Keyed variable table datapath
// Row memory, valid bits, row scan compare, flash address and result register.
// ----------------------------------------------------------------------------
`include "keyed_variable_table_assert.svh"

module kvt_dpath import kvt_pkg::*; #(
	parameter int ROW_COUNT  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  kvt_cmd_t                cmd,
	output kvt_sts_t                sts,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    action,
	input  logic [KEY_W-1:0]        lookup_key,
	input  logic signed [DATA_W-1:0] write_data,
	input  logic                    write_save_flag,
	input  logic                    write_readable,
	output logic                    done,
	output logic                    success,
	output logic signed [DATA_W-1:0] read_data,
	output logic                    read_save_flag,
	output logic                    read_readable,
	output logic                    flash_write_request,
	output logic [ADDR_W-1:0]       flash_write_address
);

	localparam int IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
	localparam int VAL_W = VALUE_BITS + 2;

	// Configuration registers.
	logic [ADDR_W-1:0] base_q;
	logic [SLOT_W-1:0] slot_q;

	// Captured transaction.
	logic                  action_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] data_q;
	logic                  save_q;
	logic                  readable_q;
	logic [ADDR_W-1:0]     prod_q;

	// Row storage.
	logic [ROW_COUNT-1:0] valid_q;
	logic [KEY_W-1:0]     key_mem [ROW_COUNT];
	logic [VAL_W-1:0]     val_mem [ROW_COUNT];

	// Scan pipeline.
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] idx_s1;
	logic [KEY_W-1:0] rd_key_s1;
	logic [VAL_W-1:0] rd_val_s1;
	logic             cmp_s1;

	// Scan results.
	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [VAL_W-1:0] match_val_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// Result registers.
	logic                  done_q;
	logic                  success_q;
	logic [DATA_W-1:0]     read_data_q;
	logic                  read_save_q;
	logic                  read_readable_q;
	logic                  flash_req_q;
	logic [ADDR_W-1:0]     flash_addr_q;

	logic             hit;
	logic             ins_ok;
	logic             sel_ok;
	logic [IDX_W-1:0] row_sel;
	logic [63:0]      data_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			slot_q <= SLOT_SIZE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FLASH_BASE: base_q <= cfg_data[ADDR_W-1:0];
				REG_SLOT_SIZE:  slot_q <= cfg_data[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= action;
			key_q      <= lookup_key;
			data_q     <= VALUE_BITS'(64'($unsigned(write_data)));
			save_q     <= write_save_flag;
			readable_q <= write_readable;
			prod_q     <= {{(ADDR_W-KEY_W){1'b0}}, lookup_key} *
				{{(ADDR_W-SLOT_W){1'b0}}, slot_q};
		end
	end

	assign sts.scan_last = (scan_idx_q == IDX_W'(ROW_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_s1     <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan;
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (cmd.scan && !sts.scan_last) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_key_s1 <= key_mem[scan_idx_q];
			rd_val_s1 <= val_mem[scan_idx_q];
			idx_s1    <= scan_idx_q;
		end
	end

	assign hit = valid_q[idx_s1] && (rd_key_s1 == key_q);

	// The scan runs in ascending row order, so the first hit and the first
	// free row found are the lowest-numbered ones.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmd.load) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmp_s1) begin
			if (hit && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!valid_q[idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_s1 && hit && !match_found_q) begin
			match_idx_q <= idx_s1;
			match_val_q <= rd_val_s1;
		end
		if (cmp_s1 && !valid_q[idx_s1] && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign row_sel = match_found_q ? match_idx_q : free_idx_q;
	assign ins_ok  = match_found_q || free_found_q;
	assign sel_ok  = match_found_q && match_val_q[VALUE_BITS+1];
	assign data_ext = {{(64-VALUE_BITS){match_val_q[VALUE_BITS-1]}},
		match_val_q[VALUE_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && (action_q == ACT_INSERT) && ins_ok) begin
			valid_q[row_sel] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (action_q == ACT_INSERT) && ins_ok) begin
			key_mem[row_sel] <= key_q;
			val_mem[row_sel] <= {readable_q, save_q, data_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (action_q == ACT_INSERT) begin
				success_q       <= ins_ok;
				read_data_q     <= '0;
				read_save_q     <= 1'b0;
				read_readable_q <= 1'b0;
				flash_req_q     <= ins_ok && save_q;
				flash_addr_q    <= (ins_ok && save_q) ? (base_q + prod_q) : '0;
			end else begin
				success_q       <= sel_ok;
				read_data_q     <= sel_ok ? data_ext[DATA_W-1:0] : '0;
				read_save_q     <= sel_ok && match_val_q[VALUE_BITS];
				read_readable_q <= sel_ok;
				flash_req_q     <= 1'b0;
				flash_addr_q    <= '0;
			end
		end
	end

	assign done                = done_q;
	assign success             = success_q;
	assign read_data           = read_data_q;
	assign read_save_flag      = read_save_q;
	assign read_readable       = read_readable_q;
	assign flash_write_request = flash_req_q;
	assign flash_write_address = flash_addr_q;

	`KVT_ASSERT(a_commit_done, clk, arst_n, cmd.commit |=> done_q, "commit without result strobe")
	`KVT_NEVER(a_free_row_valid, clk, arst_n, cmd.commit && free_found_q && valid_q[free_idx_q], "free row already valid at commit")
	`KVT_NEVER(a_flash_on_fail, clk, arst_n, done_q && flash_req_q && (!success_q || read_readable_q), "flash request without successful insert")

endmodule

// ===== rtl/core/keyed_variable_table.sv =====
// ----------------------------------------------------------------------------
// Keyed variable table
// Keyed table of value words with insert/update, select and flash requests.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is taken at a clock edge where start is high and busy is low.
// action selects insert/update (0) or select (1); lookup_key is the row key.
// Each transaction gives exactly one result: done is high for one cycle and
// success, the read fields and the flash request fields are valid with it.
// The receiver cannot stall; the result must be taken in that cycle.
// From the accepting edge a transaction passes through the row scan, the
// compare, the commit and the result register, and a new transaction can
// start in the result cycle. The row scan reads one row of the row memory
// per cycle through its single read port.
// Registers are written through cfg_write/cfg_index/cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// Reset clears all rows to empty, the flash base to 0 and the slot size to
// 256; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_variable_table import kvt_pkg::*; #(
	parameter int ROW_COUNT  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     action,
	input  logic [KEY_W-1:0]         lookup_key,
	input  logic signed [DATA_W-1:0] write_data,
	input  logic                     write_save_flag,
	input  logic                     write_readable,
	output logic                     done,
	output logic                     success,
	output logic signed [DATA_W-1:0] read_data,
	output logic                     read_save_flag,
	output logic                     read_readable,
	output logic                     flash_write_request,
	output logic [ADDR_W-1:0]        flash_write_address,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	kvt_cmd_t cmd;
	kvt_sts_t sts;

	kvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	kvt_dpath #(
		.ROW_COUNT  (ROW_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.cfg_write           (cfg_write),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.action              (action),
		.lookup_key          (lookup_key),
		.write_data          (write_data),
		.write_save_flag     (write_save_flag),
		.write_readable      (write_readable),
		.done                (done),
		.success             (success),
		.read_data           (read_data),
		.read_save_flag      (read_save_flag),
		.read_readable       (read_readable),
		.flash_write_request (flash_write_request),
		.flash_write_address (flash_write_address)
	);

endmodule
